/* sv/fts_pkg.sv */
// ----------------------------------------------------------------------------
// fts_pkg
// Shared types and constants of the frame timestamp trailer strip block.
// ----------------------------------------------------------------------------
package fts_pkg;

  // trailer layout: 8 timestamp bytes then 4 magic bytes
  localparam int TRAILER_BYTES = 12;
  localparam int STAMP_BYTES   = 8;
  localparam int MARK_BYTES    = 4;
  localparam int CNT_W         = 4;
  localparam int STAMP_W       = 64;
  localparam int MARK_W        = 32;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIP_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_WORD   = 2'd1;

  // queue depths
  localparam int CMD_DEPTH = 2;
  localparam int RES_DEPTH = 2;

  // input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_last;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [7:0]                out_byte;
    logic                      byte_valid;
    logic                      frame_end;
    logic                      trailer_found;
    logic signed [STAMP_W-1:0] ts_value;
    logic                      has_timestamp;
  } out_item_t;

  // class of an accepted byte
  typedef enum logic [1:0] {
    CMD_PASS  = 2'd0,
    CMD_HOLD  = 2'd1,
    CMD_CLOSE = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_last;
    cmd_kind_t  kind;
  } cmd_t;

endpackage

/* sv/frame_timestamp_trailer_strip.sv */
// ----------------------------------------------------------------------------
// frame_timestamp_trailer_strip
// Strips a 12-byte timestamp trailer from received frames and, while stripping
// is enabled, reports a status result with the decoded timestamp at each frame end.
// ----------------------------------------------------------------------------
//  channel   ports                                   transfer when
//  input     in_push, in_data, in_full               in_push && !in_full
//  result    out_pop, out_item, out_empty            out_pop && !out_empty
//  config    cfg_valid, cfg_index, cfg_data, cfg_ready  cfg_valid && cfg_ready
//
//  the back sequencer issues at most one result per cycle; a held byte enters
//  the window, and with a full window the oldest held byte leaves as a payload
//  result; a disabled byte first flushes every held byte, then passes itself;
//  a frame close flushes the held bytes (up to 12) unless the trailer matches,
//  then issues the status result. a passed byte reaches the out ports through
//  the command queue and then the result queue.
//  synchronous active-low reset empties both queues and the held window.
//  a full result queue stalls the sequencer; a full command queue raises
//  in_full; cfg_ready is always high.
// ----------------------------------------------------------------------------
module frame_timestamp_trailer_strip #(
  parameter int CMD_DEPTH = fts_pkg::CMD_DEPTH,
  parameter int RES_DEPTH = fts_pkg::RES_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  input  fts_pkg::in_item_t                 in_data,
  output logic                              in_full,
  input  logic                              out_pop,
  output fts_pkg::out_item_t                out_item,
  output logic                              out_empty,
  input  logic                              cfg_valid,
  input  logic [fts_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fts_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                              cfg_ready
);

  logic                       strip_en_r;
  logic [fts_pkg::MARK_W-1:0] magic_r;
  fts_pkg::cmd_t              cmd;
  logic                       cmd_empty, cmd_pop;
  logic                       res_full, res_push;
  fts_pkg::out_item_t         res;
  logic [$bits(fts_pkg::out_item_t)-1:0] out_bits;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strip_en_r <= 1'b0;
      magic_r    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        fts_pkg::CFG_STRIP_ENABLE: strip_en_r <= cfg_data[0];
        fts_pkg::CFG_MAGIC_WORD:   magic_r    <= cfg_data[fts_pkg::MARK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // front: transfer and classify
  fts_front #(
    .CMD_DEPTH (CMD_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .strip_en  (strip_en_r),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .cmd_empty (cmd_empty)
  );

  // back: window, trailer check, result sequencing
  fts_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .magic     (magic_r),
    .cmd       (cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  // result queue
  fts_fifo #(
    .WIDTH ($bits(fts_pkg::out_item_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res),
    .full    (res_full),
    .rd_en   (out_pop),
    .rd_data (out_bits),
    .empty   (out_empty)
  );

  assign out_item = fts_pkg::out_item_t'(out_bits);

endmodule

/* sv/fts_fifo.sv */
// ----------------------------------------------------------------------------
// fts_fifo
// Small register queue with first-word fall-through read.
// ----------------------------------------------------------------------------
module fts_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    cnt_r;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* sv/fts_front.sv */
// ----------------------------------------------------------------------------
// fts_front
// Accepts input bytes, tags each as pass, hold or close, and queues them.
// ----------------------------------------------------------------------------
module fts_front #(
  parameter int CMD_DEPTH = fts_pkg::CMD_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             strip_en,
  input  logic             in_push,
  input  fts_pkg::in_item_t in_data,
  output logic             in_full,
  input  logic             cmd_pop,
  output fts_pkg::cmd_t    cmd,
  output logic             cmd_empty
);

  fts_pkg::cmd_t             cmd_in;
  logic [$bits(fts_pkg::cmd_t)-1:0] cmd_bits;

  // classify on the enable seen at transfer time
  always_comb begin
    cmd_in.data_byte  = in_data.data_byte;
    cmd_in.frame_last = in_data.frame_last;
    if (!strip_en) begin
      cmd_in.kind = fts_pkg::CMD_PASS;
    end else if (in_data.frame_last) begin
      cmd_in.kind = fts_pkg::CMD_CLOSE;
    end else begin
      cmd_in.kind = fts_pkg::CMD_HOLD;
    end
  end

  // command queue toward the back part
  fts_fifo #(
    .WIDTH ($bits(fts_pkg::cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_push),
    .wr_data (cmd_in),
    .full    (in_full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_bits),
    .empty   (cmd_empty)
  );

  assign cmd = fts_pkg::cmd_t'(cmd_bits);

endmodule

/* sv/fts_back.sv */
// ----------------------------------------------------------------------------
// fts_back
// Holds the newest trailer-sized window, checks the trailer at frame end and
// issues at most one result per cycle while the result queue has room.
// ----------------------------------------------------------------------------
module fts_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [fts_pkg::MARK_W-1:0]       magic,
  input  fts_pkg::cmd_t                    cmd,
  input  logic                             cmd_empty,
  output logic                             cmd_pop,
  input  logic                             res_full,
  output logic                             res_push,
  output fts_pkg::out_item_t               res
);

  localparam int CW = fts_pkg::CNT_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(fts_pkg::TRAILER_BYTES);
  localparam logic [CW-1:0] TAIL     = CW'(fts_pkg::TRAILER_BYTES - 1);

  typedef enum logic {
    ST_RUN,
    ST_CLOSE
  } state_t;

  state_t                         state_r, state_nxt;
  logic [7:0]                     held_r [fts_pkg::TRAILER_BYTES];
  logic [CW-1:0]                  cnt_r, cnt_nxt;
  logic signed [fts_pkg::STAMP_W-1:0] last_ts_r, last_ts_nxt;
  logic                           seen_r, seen_nxt;
  logic                           do_shift, do_ins;
  logic [CW-1:0]                  ins_idx;
  logic [fts_pkg::STAMP_W-1:0]    stamp;
  logic [fts_pkg::MARK_W-1:0]     mark;
  logic                           found;

  // trailer fields read big-endian from the window
  always_comb begin
    stamp = '0;
    mark  = '0;
    for (int i = 0; i < fts_pkg::STAMP_BYTES; i++) begin
      stamp = {stamp[fts_pkg::STAMP_W-9:0], held_r[i]};
    end
    for (int i = 0; i < fts_pkg::MARK_BYTES; i++) begin
      mark = {mark[fts_pkg::MARK_W-9:0], held_r[fts_pkg::STAMP_BYTES + i]};
    end
  end

  assign found = (cnt_r == FULL_CNT) && (mark == magic);

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    last_ts_nxt = last_ts_r;
    seen_nxt    = seen_r;
    cmd_pop     = 1'b0;
    res_push    = 1'b0;
    do_shift    = 1'b0;
    do_ins      = 1'b0;
    ins_idx     = cnt_r;
    // default result: oldest held byte as payload
    res.out_byte         = held_r[0];
    res.byte_valid       = 1'b1;
    res.frame_end        = 1'b0;
    res.trailer_found    = 1'b0;
    res.ts_value         = last_ts_r;
    res.has_timestamp    = seen_r;

    unique case (state_r)
      ST_RUN: begin
        if (!cmd_empty) begin
          unique case (cmd.kind)
            fts_pkg::CMD_PASS: begin
              if (!res_full) begin
                res_push = 1'b1;
                if (cnt_r != '0) begin
                  do_shift = 1'b1;
                  cnt_nxt  = cnt_r - 1'b1;
                end else begin
                  res.out_byte  = cmd.data_byte;
                  res.frame_end = cmd.frame_last;
                  cmd_pop       = 1'b1;
                end
              end
            end
            fts_pkg::CMD_HOLD, fts_pkg::CMD_CLOSE: begin
              if (cnt_r == FULL_CNT) begin
                // window full: oldest leaves, new byte enters at the tail
                if (!res_full) begin
                  res_push = 1'b1;
                  do_shift = 1'b1;
                  do_ins   = 1'b1;
                  ins_idx  = TAIL;
                  cmd_pop  = 1'b1;
                end
              end else begin
                do_ins  = 1'b1;
                cnt_nxt = cnt_r + 1'b1;
                cmd_pop = 1'b1;
              end
              if (cmd_pop && cmd.kind == fts_pkg::CMD_CLOSE) begin
                state_nxt = ST_CLOSE;
              end
            end
            default: begin
              cmd_pop = 1'b1;
            end
          endcase
        end
      end
      ST_CLOSE: begin
        if (!res_full) begin
          res_push = 1'b1;
          if (found) begin
            res.out_byte         = '0;
            res.byte_valid       = 1'b0;
            res.frame_end        = 1'b1;
            res.trailer_found    = 1'b1;
            res.ts_value         = stamp;
            res.has_timestamp    = 1'b1;
            last_ts_nxt          = stamp;
            seen_nxt             = 1'b1;
            cnt_nxt              = '0;
            state_nxt            = ST_RUN;
          end else if (cnt_r != '0) begin
            do_shift = 1'b1;
            cnt_nxt  = cnt_r - 1'b1;
          end else begin
            res.out_byte   = '0;
            res.byte_valid = 1'b0;
            res.frame_end  = 1'b1;
            state_nxt      = ST_RUN;
          end
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  // state, counters and held window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_RUN;
      cnt_r     <= '0;
      last_ts_r <= '0;
      seen_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      last_ts_r <= last_ts_nxt;
      seen_r    <= seen_nxt;
    end
    if (do_shift) begin
      for (int i = 0; i < fts_pkg::TRAILER_BYTES - 1; i++) begin
        held_r[i] <= held_r[i + 1];
      end
    end
    if (do_ins) begin
      held_r[ins_idx] <= cmd.data_byte;
    end
  end

endmodule

/* sv/fts_checker.sv */
// ----------------------------------------------------------------------------
// fts_checker
// Port-level checks of the trailer strip block, bound to the top level.
// ----------------------------------------------------------------------------
module fts_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_pop,
  input logic               out_empty,
  input fts_pkg::out_item_t out_item
);

  // a status result always closes a frame run
  a_status_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_item.byte_valid) |-> out_item.frame_end)
    else $error("status result without frame_end");

  // payload results never claim a trailer
  a_found_status: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.trailer_found) |-> !out_item.byte_valid)
    else $error("trailer_found on a payload result");

  // status results carry a zero byte
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_item.byte_valid) |-> (out_item.out_byte == 8'd0))
    else $error("nonzero byte on status result");

  // once a timestamp is seen it stays seen
  a_seen_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pop && !out_empty && out_item.has_timestamp)
      |=> (out_empty || out_item.has_timestamp))
    else $error("has_timestamp dropped");

  // a waiting result holds while not taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_item)))
    else $error("waiting result changed");

endmodule

bind frame_timestamp_trailer_strip fts_checker u_fts_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_pop   (out_pop),
  .out_empty (out_empty),
  .out_item  (out_item)
);
